// File: sv/etm_pkg.sv
// Shared types, constants and the arctangent table for the Euler transform matrix block.
// No dependencies; every other file in this folder imports this package.
package etm_pkg;

    // Default number of rotation cells, and the length of the arctangent table.
    localparam int TRIG_STAGES_DEF = 16;
    localparam int ATAN_LEN        = 24;

    // Internal fixed-point word (Q30 with headroom), divider sizes, word width.
    localparam int Q_W      = 34;
    localparam int DIV_BITS = 28;
    localparam int DEN_W    = 16;
    localparam int WORD_W   = 32;
    localparam int LANES    = 9;

    localparam logic signed [Q_W-1:0] Q30_PI       = 34'sd3373259426;
    localparam logic signed [Q_W-1:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [Q_W-1:0] Q30_TWO_PI   = 34'sd6746518852;
    localparam logic signed [Q_W-1:0] CORDIC_START = 34'sd652032874;

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [WORD_W-1:0] t_word;

    // Input request payload.
    typedef struct packed {
        logic                mode;
        logic signed [15:0]  angle_x;
        logic signed [15:0]  angle_y;
        logic signed [15:0]  angle_z;
        logic signed [15:0]  scale_x;
        logic signed [15:0]  scale_y;
        logic signed [15:0]  scale_z;
        logic signed [31:0]  move_x;
        logic signed [31:0]  move_y;
        logic signed [31:0]  move_z;
    } t_etm_in;

    // Result request payload.
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m30;
        logic signed [31:0] m31;
        logic signed [31:0] m32;
    } t_etm_out;

    // One rotation lane: vector, residual angle, and the half-turn flag.
    typedef struct packed {
        t_q   x;
        t_q   y;
        t_q   z;
        logic flip;
    } t_etm_rot;

    // Fields that ride along the rotation cells untouched.
    typedef struct packed {
        logic               mode;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } t_etm_side;

    // One divider lane: partial remainder, dividend shifting into quotient,
    // divisor magnitude, result sign, and a bypass value for lanes that skip division.
    typedef struct packed {
        logic [DEN_W-1:0]    rem;
        logic [DIV_BITS-1:0] num;
        logic [DEN_W-1:0]    den;
        logic                neg;
        logic                use_fixed;
        t_word               fixed;
    } t_etm_div;

    // Truncated arctangent of 2^-idx in Q30.
    function automatic t_q atan_val(input int unsigned idx);
        t_q v;
        case (idx)
            0:       v = 34'sh03243F6A8;
            1:       v = 34'sh01DAC6705;
            2:       v = 34'sh00FADBAFC;
            3:       v = 34'sh007F56EA6;
            4:       v = 34'sh003FEAB76;
            5:       v = 34'sh001FFD55B;
            6:       v = 34'sh000FFFAAA;
            7:       v = 34'sh0007FFF55;
            8:       v = 34'sh0003FFFEA;
            9:       v = 34'sh0001FFFFD;
            10:      v = 34'sh0000FFFFF;
            11:      v = 34'sh00007FFFF;
            12:      v = 34'sh00003FFFF;
            13:      v = 34'sh00001FFFF;
            14:      v = 34'sh00000FFFF;
            15:      v = 34'sh000007FFF;
            16:      v = 34'sh000003FFF;
            17:      v = 34'sh000001FFF;
            18:      v = 34'sh000000FFF;
            19:      v = 34'sh0000007FF;
            20:      v = 34'sh0000003FF;
            21:      v = 34'sh0000001FF;
            22:      v = 34'sh0000000FF;
            23:      v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/etm_cordic_cell.sv
// One rotation-mode CORDIC cell working on three angle lanes at once.
// Depends on etm_pkg for the lane types and the arctangent table.
module etm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  etm_pkg::t_etm_rot  [2:0]  i_rot,
    input  etm_pkg::t_etm_side        i_side,
    output etm_pkg::t_etm_rot  [2:0]  o_rot,
    output etm_pkg::t_etm_side        o_side
);
    import etm_pkg::*;

    localparam t_q ATAN = atan_val(STAGE);

    t_etm_rot [2:0] r_rot;
    t_etm_rot [2:0] n_rot;
    t_etm_side      r_side;

    // Rotate each lane toward zero residual angle by one micro-rotation.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            t_q x;
            t_q y;
            t_q z;
            t_q dx;
            t_q dy;
            x  = i_rot[l].x;
            y  = i_rot[l].y;
            z  = i_rot[l].z;
            dx = y >>> STAGE;
            dy = x >>> STAGE;
            n_rot[l].flip = i_rot[l].flip;
            if (!z[Q_W-1]) begin
                n_rot[l].x = x - dx;
                n_rot[l].y = y + dy;
                n_rot[l].z = z - ATAN;
            end else begin
                n_rot[l].x = x + dx;
                n_rot[l].y = y - dy;
                n_rot[l].z = z + ATAN;
            end
        end
    end

    // Hand the lanes and the side fields to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot  <= n_rot;
            r_side <= i_side;
        end
    end

    assign o_rot  = r_rot;
    assign o_side = r_side;

endmodule

// File: sv/etm_div_cell.sv
// One restoring-division cell: produces one quotient bit for each of the nine lanes.
// Depends on etm_pkg for the divider lane type.
module etm_div_cell (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  etm_pkg::t_etm_div [etm_pkg::LANES-1:0]  i_lane,
    input  etm_pkg::t_word    [2:0]                 i_tr,
    output etm_pkg::t_etm_div [etm_pkg::LANES-1:0]  o_lane,
    output etm_pkg::t_word    [2:0]                 o_tr
);
    import etm_pkg::*;

    t_etm_div [LANES-1:0] r_lane;
    t_etm_div [LANES-1:0] n_lane;
    t_word    [2:0]       r_tr;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [DEN_W:0] t;
            logic           bit_q;
            t          = {i_lane[l].rem, i_lane[l].num[DIV_BITS-1]};
            bit_q      = (t >= {1'b0, i_lane[l].den});
            n_lane[l]  = i_lane[l];
            if (bit_q) begin
                n_lane[l].rem = DEN_W'(t - {1'b0, i_lane[l].den});
            end else begin
                n_lane[l].rem = t[DEN_W-1:0];
            end
            n_lane[l].num = {i_lane[l].num[DIV_BITS-2:0], bit_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_tr   <= i_tr;
        end
    end

    assign o_lane = r_lane;
    assign o_tr   = r_tr;

endmodule

// File: sv/euler_transform_matrix.sv
// Euler Y-X-Z model / normal matrix generator: top level and pipeline control.
// Depends on etm_pkg, etm_cordic_cell and etm_div_cell.
//
// Usage: each input request carries three angles (Q4.12 rad), three scales (Q8.8),
// three translations (Q16.16) and a mode. Each result request carries the twelve
// non-constant entries of the 4x4 matrix R = Ry * Rx * Rz, columns scaled by the
// scale (mode 0) or by its reciprocal (mode 1), translation in the last row in
// mode 0 and zero in mode 1. All entries are Q16.16 and saturate.
// Both channels use valid/ready. One request is taken every cycle while o_ready
// is high; the pipeline is TRIG_STAGES + 37 stages deep. The depth is set by the
// chain of rotation cells and the 28 one-bit divider cells. Each stage has its
// own valid bit; a stalled receiver holds the output register, and stages behind
// it keep filling empty slots, so requests are still taken until the pipeline is
// full. Reset empties the pipeline by clearing every valid bit; there is no setup
// to do afterwards.
module euler_transform_matrix #(
    parameter int TRIG_STAGES = etm_pkg::TRIG_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  etm_pkg::t_etm_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output etm_pkg::t_etm_out o_data
);
    import etm_pkg::*;

    localparam int PROD_W = Q_W + 16;
    localparam int ST_R1  = 0;
    localparam int ST_R2  = 1;
    localparam int ST_C0  = 2;
    localparam int ST_P0  = ST_C0 + TRIG_STAGES;
    localparam int ST_P1  = ST_P0 + 1;
    localparam int ST_P2  = ST_P1 + 1;
    localparam int ST_P3  = ST_P2 + 1;
    localparam int ST_S1  = ST_P3 + 1;
    localparam int ST_S2  = ST_S1 + 1;
    localparam int ST_D0  = ST_S2 + 1;
    localparam int ST_OUT = ST_D0 + DIV_BITS;
    localparam int NST    = ST_OUT + 1;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2097152);
    localparam logic signed [PROD_W-1:0] W_MAX    = PROD_W'(32'sh7FFFFFFF);
    localparam logic signed [PROD_W-1:0] W_MIN    = -PROD_W'(64'sd2147483648);
    localparam t_word                    WORD_MAX = 32'sh7FFFFFFF;
    localparam t_word                    WORD_MIN = 32'sh80000000;

    // Q30 product with floor, operands known to fit 32 bits.
    function automatic t_q mul30(input t_q a, input t_q b);
        logic signed [63:0] p;
        p = $signed(a[31:0]) * $signed(b[31:0]);
        return Q_W'(p >>> 30);
    endfunction

    function automatic t_word sat_word(input logic signed [PROD_W-1:0] v);
        t_word w;
        if (v > W_MAX) begin
            w = WORD_MAX;
        end else if (v < W_MIN) begin
            w = WORD_MIN;
        end else begin
            w = v[WORD_W-1:0];
        end
        return w;
    endfunction

    // Per-stage valid bits; a stage advances when empty or when its successor advances.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NST-1];

    // Stage R1: widen the angles to Q30 and bring them into [-pi, pi].
    t_q        r_r1_z [3];
    t_q        n_r1_z [3];
    t_etm_side r_r1_side;
    t_etm_side n_r1_side;

    always_comb begin
        logic signed [15:0] ang [3];
        ang[0] = i_data.angle_y;
        ang[1] = i_data.angle_x;
        ang[2] = i_data.angle_z;
        for (int l = 0; l < 3; l++) begin
            t_q z;
            z = $signed({ang[l], 18'b0});
            if (z > Q30_PI) begin
                n_r1_z[l] = z - Q30_TWO_PI;
            end else if (z < -Q30_PI) begin
                n_r1_z[l] = z + Q30_TWO_PI;
            end else begin
                n_r1_z[l] = z;
            end
        end
        n_r1_side.mode    = i_data.mode;
        n_r1_side.scale_x = i_data.scale_x;
        n_r1_side.scale_y = i_data.scale_y;
        n_r1_side.scale_z = i_data.scale_z;
        n_r1_side.move_x  = i_data.move_x;
        n_r1_side.move_y  = i_data.move_y;
        n_r1_side.move_z  = i_data.move_z;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_R1]) begin
            r_r1_z    <= n_r1_z;
            r_r1_side <= n_r1_side;
        end
    end

    // Stage R2: fold into [-pi/2, pi/2] and load the starting vector.
    t_etm_rot [2:0] r_r2_rot;
    t_etm_rot [2:0] n_r2_rot;
    t_etm_side      r_r2_side;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_r2_rot[l].x = CORDIC_START;
            n_r2_rot[l].y = '0;
            if (r_r1_z[l] > Q30_HALF_PI) begin
                n_r2_rot[l].z    = r_r1_z[l] - Q30_PI;
                n_r2_rot[l].flip = 1'b1;
            end else if (r_r1_z[l] < -Q30_HALF_PI) begin
                n_r2_rot[l].z    = r_r1_z[l] + Q30_PI;
                n_r2_rot[l].flip = 1'b1;
            end else begin
                n_r2_rot[l].z    = r_r1_z[l];
                n_r2_rot[l].flip = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_R2]) begin
            r_r2_rot  <= n_r2_rot;
            r_r2_side <= r_r1_side;
        end
    end

    // Chain of rotation cells.
    t_etm_rot [2:0] rot_q  [0:TRIG_STAGES];
    t_etm_side      side_q [0:TRIG_STAGES];

    assign rot_q[0]  = r_r2_rot;
    assign side_q[0] = r_r2_side;

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cordic
        etm_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv[ST_C0+g]),
            .i_rot  (rot_q[g]),
            .i_side (side_q[g]),
            .o_rot  (rot_q[g+1]),
            .o_side (side_q[g+1])
        );
    end

    // Stage P0: undo the half-turn fold to get sine and cosine.
    t_q        r_sn [3];
    t_q        r_cs [3];
    t_etm_side r_p0_side;

    always_ff @(posedge i_clk) begin
        if (adv[ST_P0]) begin
            for (int l = 0; l < 3; l++) begin
                r_sn[l] <= rot_q[TRIG_STAGES][l].flip ? -rot_q[TRIG_STAGES][l].y
                                                      : rot_q[TRIG_STAGES][l].y;
                r_cs[l] <= rot_q[TRIG_STAGES][l].flip ? -rot_q[TRIG_STAGES][l].x
                                                      : rot_q[TRIG_STAGES][l].x;
            end
            r_p0_side <= side_q[TRIG_STAGES];
        end
    end

    // Stage P1: two-factor products (lane 0 is y, lane 1 is x, lane 2 is z).
    t_q r_c1c3, r_s1s2, r_c1s2, r_c3s1, r_c2s3, r_c2c3, r_s1s3, r_c2s1, r_c1s3, r_c1c2;
    t_q r_p1_s2, r_p1_s3;
    t_etm_side r_p1_side;

    always_ff @(posedge i_clk) begin
        if (adv[ST_P1]) begin
            r_c1c3    <= mul30(r_cs[0], r_cs[2]);
            r_s1s2    <= mul30(r_sn[0], r_sn[1]);
            r_c1s2    <= mul30(r_cs[0], r_sn[1]);
            r_c3s1    <= mul30(r_cs[2], r_sn[0]);
            r_c2s3    <= mul30(r_cs[1], r_sn[2]);
            r_c2c3    <= mul30(r_cs[1], r_cs[2]);
            r_s1s3    <= mul30(r_sn[0], r_sn[2]);
            r_c2s1    <= mul30(r_cs[1], r_sn[0]);
            r_c1s3    <= mul30(r_cs[0], r_sn[2]);
            r_c1c2    <= mul30(r_cs[0], r_cs[1]);
            r_p1_s2   <= r_sn[1];
            r_p1_s3   <= r_sn[2];
            r_p1_side <= r_p0_side;
        end
    end

    // Stage P2: three-factor products; two-factor terms ride along.
    t_q r_s1s2s3, r_c1s2s3, r_c3s1s2, r_c1c3s2;
    t_q r_p2_c1c3, r_p2_c3s1, r_p2_c1s3, r_p2_s1s3, r_p2_c2s3, r_p2_c2c3;
    t_q r_p2_c2s1, r_p2_c1c2, r_p2_s2;
    t_etm_side r_p2_side;

    always_ff @(posedge i_clk) begin
        if (adv[ST_P2]) begin
            r_s1s2s3  <= mul30(r_s1s2, r_p1_s3);
            r_c1s2s3  <= mul30(r_c1s2, r_p1_s3);
            r_c3s1s2  <= mul30(r_c3s1, r_p1_s2);
            r_c1c3s2  <= mul30(r_c1c3, r_p1_s2);
            r_p2_c1c3 <= r_c1c3;
            r_p2_c3s1 <= r_c3s1;
            r_p2_c1s3 <= r_c1s3;
            r_p2_s1s3 <= r_s1s3;
            r_p2_c2s3 <= r_c2s3;
            r_p2_c2c3 <= r_c2c3;
            r_p2_c2s1 <= r_c2s1;
            r_p2_c1c2 <= r_c1c2;
            r_p2_s2   <= r_p1_s2;
            r_p2_side <= r_p1_side;
        end
    end

    // Stage P3: rotation matrix entries, column-major.
    t_q        r_rm [LANES];
    t_etm_side r_p3_side;

    always_ff @(posedge i_clk) begin
        if (adv[ST_P3]) begin
            r_rm[0]   <= r_p2_c1c3 + r_s1s2s3;
            r_rm[1]   <= r_p2_c2s3;
            r_rm[2]   <= r_c1s2s3 - r_p2_c3s1;
            r_rm[3]   <= r_c3s1s2 - r_p2_c1s3;
            r_rm[4]   <= r_p2_c2c3;
            r_rm[5]   <= r_c1c3s2 + r_p2_s1s3;
            r_rm[6]   <= r_p2_c2s1;
            r_rm[7]   <= -r_p2_s2;
            r_rm[8]   <= r_p2_c1c2;
            r_p3_side <= r_p2_side;
        end
    end

    // Stage S1: scale product, rounded dividend and divisor magnitude per entry.
    logic signed [PROD_W-1:0] r_prod [LANES];
    logic [DIV_BITS-1:0]      r_n6   [LANES];
    logic [DEN_W-1:0]         r_den  [LANES];
    logic [LANES-1:0]         r_neg, r_rneg, r_rnz, r_szero;
    t_etm_side                r_s1_side;

    always_ff @(posedge i_clk) begin
        if (adv[ST_S1]) begin
            for (int k = 0; k < LANES; k++) begin
                logic signed [15:0] s;
                logic signed [16:0] se;
                logic [16:0]        as;
                t_q                 ar;
                logic [Q_W:0]       num;
                s   = (k < 3) ? r_p3_side.scale_x
                    : (k < 6) ? r_p3_side.scale_y : r_p3_side.scale_z;
                se  = {s[15], s};
                as  = se[16] ? 17'(-se) : 17'(se);
                ar  = r_rm[k][Q_W-1] ? -r_rm[k] : r_rm[k];
                num = {1'b0, ar} + (Q_W+1)'({as[15:0], 5'b0});
                r_prod[k]  <= r_rm[k] * s;
                r_n6[k]    <= num[DIV_BITS+5:6];
                r_den[k]   <= as[DEN_W-1:0];
                r_neg[k]   <= r_rm[k][Q_W-1] ^ s[15];
                r_rneg[k]  <= r_rm[k][Q_W-1];
                r_rnz[k]   <= (r_rm[k] != '0);
                r_szero[k] <= (s == '0);
            end
            r_s1_side <= r_p3_side;
        end
    end

    // Stage S2: mode 0 results and zero-scale results bypass the divider.
    t_etm_div [LANES-1:0] r_s2_lane;
    t_word    [2:0]       r_s2_tr;

    always_ff @(posedge i_clk) begin
        if (adv[ST_S2]) begin
            for (int k = 0; k < LANES; k++) begin
                r_s2_lane[k].rem       <= '0;
                r_s2_lane[k].num       <= r_n6[k];
                r_s2_lane[k].den       <= r_den[k];
                r_s2_lane[k].neg       <= r_neg[k];
                r_s2_lane[k].use_fixed <= !r_s1_side.mode || r_szero[k];
                if (!r_s1_side.mode) begin
                    r_s2_lane[k].fixed <= sat_word((r_prod[k] + RND_HALF) >>> 22);
                end else if (!r_rnz[k]) begin
                    r_s2_lane[k].fixed <= '0;
                end else begin
                    r_s2_lane[k].fixed <= r_rneg[k] ? WORD_MIN : WORD_MAX;
                end
            end
            r_s2_tr[0] <= r_s1_side.mode ? '0 : r_s1_side.move_x;
            r_s2_tr[1] <= r_s1_side.mode ? '0 : r_s1_side.move_y;
            r_s2_tr[2] <= r_s1_side.mode ? '0 : r_s1_side.move_z;
        end
    end

    // Chain of one-bit divider cells.
    t_etm_div [LANES-1:0] div_q [0:DIV_BITS];
    t_word    [2:0]       tr_q  [0:DIV_BITS];

    assign div_q[0] = r_s2_lane;
    assign tr_q[0]  = r_s2_tr;

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        etm_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (adv[ST_D0+g]),
            .i_lane (div_q[g]),
            .i_tr   (tr_q[g]),
            .o_lane (div_q[g+1]),
            .o_tr   (tr_q[g+1])
        );
    end

    // Output register: apply the quotient sign or take the bypass value.
    t_word [LANES-1:0] n_ent;
    t_etm_out          r_out;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            t_word q;
            q = WORD_W'(div_q[DIV_BITS][k].num);
            if (div_q[DIV_BITS][k].use_fixed) begin
                n_ent[k] = div_q[DIV_BITS][k].fixed;
            end else begin
                n_ent[k] = div_q[DIV_BITS][k].neg ? -q : q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r_out.m00 <= n_ent[0];
            r_out.m01 <= n_ent[1];
            r_out.m02 <= n_ent[2];
            r_out.m10 <= n_ent[3];
            r_out.m11 <= n_ent[4];
            r_out.m12 <= n_ent[5];
            r_out.m20 <= n_ent[6];
            r_out.m21 <= n_ent[7];
            r_out.m22 <= n_ent[8];
            r_out.m30 <= tr_q[DIV_BITS][0];
            r_out.m31 <= tr_q[DIV_BITS][1];
            r_out.m32 <= tr_q[DIV_BITS][2];
        end
    end

    assign o_data = r_out;

    // Reset empties every stage of the pipeline.
    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    // A held result is not overwritten while the receiver stalls.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_out))
        else $error("output changed during stall");

    // The x component of each rotation vector leaves the chain within the 32-bit range the multipliers use.
    for (genvar l = 0; l < 3; l++) begin : g_chk_rot
        a_rot_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[ST_P0-1] |->
                (rot_q[TRIG_STAGES][l].x[Q_W-1:31] == '0 ||
                 rot_q[TRIG_STAGES][l].x[Q_W-1:31] == '1))
            else $error("rotation vector out of range");
    end

    // Each real division ends with a remainder below its divisor.
    for (genvar k = 0; k < LANES; k++) begin : g_chk_div
        a_div_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[ST_OUT-1] && !div_q[DIV_BITS][k].use_fixed |->
                div_q[DIV_BITS][k].rem < div_q[DIV_BITS][k].den)
            else $error("divider remainder not below divisor");
    end

endmodule
